@@ hw/rtl/mfwm_pkg.sv @@
// Package for the mask flag window morphology unit.
// Holds the shared widths, flag and mode codes, and the payload and status structs.
// No dependencies.
package mfwm_pkg;

  localparam int unsigned LineDepth  = 1024;
  localparam int unsigned LineAw     = $clog2(LineDepth);
  localparam int unsigned FlagW      = 6;
  localparam int unsigned ColW       = LineAw;
  localparam int unsigned RowW       = 12;
  localparam int unsigned WidthW     = LineAw + 1;
  localparam int unsigned HeightW    = RowW + 1;
  localparam int unsigned CountW     = ColW + RowW;
  localparam int unsigned TotalW     = CountW + 1;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = HeightW;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);
  localparam int unsigned DivSteps   = CountW;
  localparam int unsigned DivCntW    = $clog2(DivSteps + 1);

  localparam logic [WidthW-1:0]  MaxWidth  = WidthW'(LineDepth);
  localparam logic [HeightW-1:0] MaxHeight = HeightW'(1 << RowW);
  localparam logic [RowW-1:0]    RowMax    = '1;

  localparam logic [FlagW-1:0] FlSolid    = 6'h01;
  localparam logic [FlagW-1:0] FlDilated  = 6'h02;
  localparam logic [FlagW-1:0] FlBoundary = 6'h04;
  localparam logic [FlagW-1:0] FlBand     = 6'h08;
  localparam logic [FlagW-1:0] FlNoHole   = 6'h10;

  typedef enum logic [1:0] {
    ModeDilate   = 2'd0,
    ModeBoundary = 2'd1,
    ModeBand     = 2'd2,
    ModeClose    = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMode     = 2'd0,
    CfgWidth    = 2'd1,
    CfgHeight   = 2'd2,
    CfgEdgeBand = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic             kind;
    logic [FlagW-1:0] pixel_flags;
  } in_item_t;

  typedef struct packed {
    logic [FlagW-1:0] result_flags;
    logic [ColW-1:0]  out_column;
    logic [RowW-1:0]  out_row;
    logic             frame_end;
  } out_item_t;

  typedef struct packed {
    logic [FlagW-1:0] up;
    logic [FlagW-1:0] mid;
    logic [FlagW-1:0] pix;
    logic             primed;
    logic [ColW-1:0]  col;
    logic [RowW-1:0]  row;
    logic             last;
    logic             left_ok;
    logic             right_ok;
    logic             up_ok;
    logic             down_ok;
  } line_item_t;

  typedef struct packed {
    logic               busy;
    logic               load;
    logic [WidthW-1:0]  eff_width;
    logic [HeightW-1:0] eff_height;
    logic [TotalW-1:0]  total;
    logic [ColW-1:0]    col;
    logic [CountW-1:0]  row;
  } geom_t;

endpackage

@@ hw/rtl/mask_flag_window_morphology_unit.sv @@
// Top level of the mask flag window morphology unit.
// Instantiates mfwm_geom, mfwm_front, mfwm_queue and mfwm_back; depends on mfwm_pkg.
//
// The unit applies one 3x3 flag rule (dilate, boundary mark, band grow or close holes) to a
// raster stream of 6-bit flag words and takes one item per clock cycle while full is low.
// Results trail the input by one row plus one pixel, so the host sends frame_width + 1 flush
// items after the last pixel.
// After reset, full stays high while the line store memory is cleared one entry per cycle.
// After every configuration write, full stays high while the output position is recomputed
// from the result count by a one-bit-per-cycle divider.
module mask_flag_window_morphology_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  mfwm_pkg::in_item_t            in_item_i,
  output logic                          empty,
  input  logic                          pop,
  output mfwm_pkg::out_item_t           out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mfwm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mfwm_pkg::CfgDataW-1:0] cfg_data_i
);

  mfwm_pkg::geom_t              geom;
  logic [1:0]                   mode;
  logic                         edge_band;
  logic [mfwm_pkg::CountW-1:0]  emitted_count;
  logic [mfwm_pkg::QueueAw:0]   queue_count;
  logic                         queue_push;
  logic                         queue_pop;
  logic                         queue_empty;
  mfwm_pkg::line_item_t         queue_in;
  mfwm_pkg::line_item_t         queue_out;

  mfwm_geom u_geom (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .emitted_count_i (emitted_count),
    .mode_o          (mode),
    .edge_band_o     (edge_band),
    .geom_o          (geom)
  );

  mfwm_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .in_item_i       (in_item_i),
    .geom_i          (geom),
    .emitted_count_o (emitted_count),
    .queue_count_i   (queue_count),
    .queue_push_o    (queue_push),
    .queue_item_o    (queue_in)
  );

  mfwm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (queue_push),
    .item_i  (queue_in),
    .pop_i   (queue_pop),
    .item_o  (queue_out),
    .empty_o (queue_empty),
    .count_o (queue_count)
  );

  mfwm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (queue_out),
    .item_empty_i (queue_empty),
    .item_pop_o   (queue_pop),
    .mode_i       (mode),
    .edge_band_i  (edge_band),
    .empty        (empty),
    .pop          (pop),
    .out_item_o   (out_item_o)
  );

endmodule

@@ hw/rtl/mfwm_geom.sv @@
// Configuration registers, frame size product and the position divider.
// Recomputes the output position from the result count after each register write.
// Depends on mfwm_pkg.
module mfwm_geom (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mfwm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mfwm_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic [mfwm_pkg::CountW-1:0]   emitted_count_i,
  output logic [1:0]                    mode_o,
  output logic                          edge_band_o,
  output mfwm_pkg::geom_t               geom_o
);

  logic [1:0]                     mode_q;
  logic [mfwm_pkg::WidthW-1:0]    width_q;
  logic [mfwm_pkg::HeightW-1:0]   height_q;
  logic                           edge_band_q;
  logic [mfwm_pkg::WidthW-1:0]    eff_width;
  logic [mfwm_pkg::HeightW-1:0]   eff_height;
  logic [mfwm_pkg::TotalW-1:0]    total_q;
  logic [mfwm_pkg::DivCntW-1:0]   div_cnt_q;
  logic                           done_q;
  logic [mfwm_pkg::WidthW-1:0]    rem_q;
  logic [mfwm_pkg::WidthW-1:0]    rem_d;
  logic [mfwm_pkg::CountW-1:0]    quo_q;
  logic [mfwm_pkg::WidthW-1:0]    trial;
  logic                           cfg_write;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= mfwm_pkg::ModeDilate;
      width_q     <= mfwm_pkg::MaxWidth;
      height_q    <= mfwm_pkg::HeightW'(1);
      edge_band_q <= 1'b0;
    end else if (cfg_write) begin
      unique case (mfwm_pkg::cfg_idx_e'(cfg_index_i))
        mfwm_pkg::CfgMode:     mode_q      <= cfg_data_i[1:0];
        mfwm_pkg::CfgWidth:    width_q     <= cfg_data_i[mfwm_pkg::WidthW-1:0];
        mfwm_pkg::CfgHeight:   height_q    <= cfg_data_i;
        mfwm_pkg::CfgEdgeBand: edge_band_q <= cfg_data_i[0];
        default:               mode_q      <= mode_q;
      endcase
    end
  end

  always_comb begin
    eff_width = width_q;
    if (width_q == '0) begin
      eff_width = mfwm_pkg::WidthW'(1);
    end else if (width_q > mfwm_pkg::MaxWidth) begin
      eff_width = mfwm_pkg::MaxWidth;
    end
    eff_height = height_q;
    if (height_q == '0) begin
      eff_height = mfwm_pkg::HeightW'(1);
    end else if (height_q > mfwm_pkg::MaxHeight) begin
      eff_height = mfwm_pkg::MaxHeight;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= mfwm_pkg::TotalW'(mfwm_pkg::LineDepth);
    end else begin
      total_q <= mfwm_pkg::TotalW'(eff_width) * mfwm_pkg::TotalW'(eff_height);
    end
  end

  // Restoring division of the result count by the width, one quotient bit per cycle.
  assign trial = {rem_q[mfwm_pkg::WidthW-2:0], quo_q[mfwm_pkg::CountW-1]};

  always_comb begin
    rem_d = trial;
    if (trial >= eff_width) begin
      rem_d = trial - eff_width;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
      done_q    <= 1'b0;
    end else if (cfg_write) begin
      div_cnt_q <= mfwm_pkg::DivCntW'(mfwm_pkg::DivSteps);
      done_q    <= 1'b0;
    end else begin
      done_q <= (div_cnt_q == mfwm_pkg::DivCntW'(1));
      if (div_cnt_q != '0) begin
        div_cnt_q <= div_cnt_q - mfwm_pkg::DivCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cfg_write) begin
      rem_q <= '0;
      quo_q <= emitted_count_i;
    end else if (div_cnt_q != '0) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[mfwm_pkg::CountW-2:0], (trial >= eff_width)};
    end
  end

  assign mode_o      = mode_q;
  assign edge_band_o = edge_band_q;

  always_comb begin
    geom_o            = '0;
    geom_o.busy       = cfg_write || (div_cnt_q != '0) || done_q;
    geom_o.load       = done_q;
    geom_o.eff_width  = eff_width;
    geom_o.eff_height = eff_height;
    geom_o.total      = total_q;
    geom_o.col        = rem_q[mfwm_pkg::ColW-1:0];
    geom_o.row        = quo_q;
  end

endmodule

@@ hw/rtl/mfwm_queue.sv @@
// Short queue of classified line items between the front and the back part.
// The front only pushes when a slot is known to be free.
// Depends on mfwm_pkg.
module mfwm_queue (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  mfwm_pkg::line_item_t           item_i,
  input  logic                           pop_i,
  output mfwm_pkg::line_item_t           item_o,
  output logic                           empty_o,
  output logic [mfwm_pkg::QueueAw:0]     count_o
);

  mfwm_pkg::line_item_t             slots_q [mfwm_pkg::QueueDepth];
  logic [mfwm_pkg::QueueAw-1:0]     wr_ptr_q;
  logic [mfwm_pkg::QueueAw-1:0]     rd_ptr_q;
  logic [mfwm_pkg::QueueAw:0]       count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + mfwm_pkg::QueueAw'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + mfwm_pkg::QueueAw'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (mfwm_pkg::QueueAw+1)'(1);
      end else if (!push_i && pop_i) begin
        count_q <= count_q - (mfwm_pkg::QueueAw+1)'(1);
      end
    end
  end

  assign item_o  = slots_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

endmodule

@@ hw/rtl/mfwm_front.sv @@
// Front part: accepts pixel and flush items, keeps the raster counters and the line stores.
// Each kept item leaves as one line item with its column of three cells and its position.
// Depends on mfwm_pkg.
module mfwm_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  mfwm_pkg::in_item_t            in_item_i,
  input  mfwm_pkg::geom_t               geom_i,
  output logic [mfwm_pkg::CountW-1:0]   emitted_count_o,
  input  logic [mfwm_pkg::QueueAw:0]    queue_count_i,
  output logic                          queue_push_o,
  output mfwm_pkg::line_item_t          queue_item_o
);

  localparam int unsigned StoreW = 2 * mfwm_pkg::FlagW;

  logic [StoreW-1:0]               line_mem [mfwm_pkg::LineDepth];
  logic [mfwm_pkg::LineAw:0]       clr_q;
  logic                            clearing;
  logic [mfwm_pkg::ColW-1:0]       in_col_q;
  logic [mfwm_pkg::RowW-1:0]       in_row_q;
  logic [mfwm_pkg::CountW-1:0]     count_q;
  logic [mfwm_pkg::ColW-1:0]       ocol_q;
  logic [mfwm_pkg::CountW-1:0]     orow_q;
  logic                            s1_valid_q;
  logic [mfwm_pkg::LineAw-1:0]     s1_addr_q;
  mfwm_pkg::line_item_t            s1_item_q;
  logic [StoreW-1:0]               rdata_q;
  logic                            byp_q;
  logic [StoreW-1:0]               byp_data_q;
  logic [StoreW-1:0]               rd_eff;
  logic [StoreW-1:0]               wdata;
  logic                            accept;
  logic                            idle_flush;
  logic                            take;
  logic                            primed;
  logic                            last;
  logic                            in_wrap;
  logic                            out_wrap;
  logic [mfwm_pkg::FlagW-1:0]      pix;
  mfwm_pkg::line_item_t            item;

  assign clearing = !clr_q[mfwm_pkg::LineAw];
  assign full     = clearing || geom_i.busy ||
                    ((queue_count_i + (mfwm_pkg::QueueAw+1)'(s1_valid_q)) >=
                     (mfwm_pkg::QueueAw+1)'(mfwm_pkg::QueueDepth));
  assign accept   = push && !full;

  assign idle_flush = in_item_i.kind && (in_col_q == '0) && (in_row_q == '0) &&
                      (count_q == '0);
  assign take       = accept && !idle_flush;
  assign pix        = in_item_i.kind ? '0 : in_item_i.pixel_flags;
  assign primed     = (in_row_q >= mfwm_pkg::RowW'(2)) ||
                      ((in_row_q == mfwm_pkg::RowW'(1)) && (in_col_q != '0));
  assign in_wrap    = (mfwm_pkg::WidthW'(in_col_q) + mfwm_pkg::WidthW'(1)) >=
                      geom_i.eff_width;
  assign out_wrap   = (mfwm_pkg::WidthW'(ocol_q) + mfwm_pkg::WidthW'(1)) >=
                      geom_i.eff_width;
  assign last       = (mfwm_pkg::TotalW'(count_q) + mfwm_pkg::TotalW'(1)) >=
                      geom_i.total;

  always_comb begin
    item          = '0;
    item.pix      = pix;
    item.primed   = primed;
    item.col      = ocol_q;
    item.row      = orow_q[mfwm_pkg::RowW-1:0];
    item.last     = last;
    item.left_ok  = (ocol_q != '0);
    item.right_ok = !out_wrap;
    item.up_ok    = (orow_q != '0);
    item.down_ok  = (mfwm_pkg::TotalW'(orow_q) + mfwm_pkg::TotalW'(1)) <
                    mfwm_pkg::TotalW'(geom_i.eff_height);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      in_col_q   <= '0;
      in_row_q   <= '0;
      count_q    <= '0;
      ocol_q     <= '0;
      orow_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (clearing) begin
        clr_q <= clr_q + (mfwm_pkg::LineAw+1)'(1);
      end
      s1_valid_q <= take;
      if (geom_i.load) begin
        ocol_q <= geom_i.col;
        orow_q <= geom_i.row;
      end else if (take) begin
        if (in_wrap) begin
          in_col_q <= '0;
          if (in_row_q != mfwm_pkg::RowMax) begin
            in_row_q <= in_row_q + mfwm_pkg::RowW'(1);
          end
        end else begin
          in_col_q <= in_col_q + mfwm_pkg::ColW'(1);
        end
        if (primed) begin
          if (last) begin
            in_col_q <= '0;
            in_row_q <= '0;
            count_q  <= '0;
            ocol_q   <= '0;
            orow_q   <= '0;
          end else begin
            count_q <= count_q + mfwm_pkg::CountW'(1);
            if (out_wrap) begin
              ocol_q <= '0;
              orow_q <= orow_q + mfwm_pkg::CountW'(1);
            end else begin
              ocol_q <= ocol_q + mfwm_pkg::ColW'(1);
            end
          end
        end
      end
    end
  end

  // The entry read for an item is written back in the following cycle, so a read of the
  // entry being written in the same cycle takes the new data instead.
  assign rd_eff = byp_q ? byp_data_q : rdata_q;
  assign wdata  = {rd_eff[mfwm_pkg::FlagW-1:0], s1_item_q.pix};

  always_ff @(posedge clk_i) begin
    if (clearing) begin
      line_mem[clr_q[mfwm_pkg::LineAw-1:0]] <= '0;
    end else if (s1_valid_q) begin
      line_mem[s1_addr_q] <= wdata;
    end
    if (take) begin
      rdata_q    <= line_mem[in_col_q];
      byp_q      <= s1_valid_q && (s1_addr_q == in_col_q);
      byp_data_q <= wdata;
      s1_addr_q  <= in_col_q;
      s1_item_q  <= item;
    end
  end

  always_comb begin
    queue_item_o     = s1_item_q;
    queue_item_o.up  = rd_eff[StoreW-1:mfwm_pkg::FlagW];
    queue_item_o.mid = rd_eff[mfwm_pkg::FlagW-1:0];
  end

  assign queue_push_o    = s1_valid_q;
  assign emitted_count_o = count_q;

endmodule

@@ hw/rtl/mfwm_back.sv @@
// Back part: shifts the 3x3 window, applies the selected rule and queues the results.
// Depends on mfwm_pkg.
module mfwm_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mfwm_pkg::line_item_t  item_i,
  input  logic                  item_empty_i,
  output logic                  item_pop_o,
  input  logic [1:0]            mode_i,
  input  logic                  edge_band_i,
  output logic                  empty,
  input  logic                  pop,
  output mfwm_pkg::out_item_t   out_item_o
);

  localparam logic [mfwm_pkg::FlagW-1:0] Sd = mfwm_pkg::FlSolid | mfwm_pkg::FlDilated;

  logic [mfwm_pkg::FlagW-1:0] win_q [9];
  logic [mfwm_pkg::FlagW-1:0] win_d [9];
  logic [mfwm_pkg::FlagW-1:0] nbr   [9];
  mfwm_pkg::out_item_t        res_q [2];
  logic                       wr_ptr_q;
  logic                       rd_ptr_q;
  logic [1:0]                 res_cnt_q;
  logic                       out_pop;
  logic                       room;
  logic                       res_push;
  logic [mfwm_pkg::FlagW-1:0] here;
  logic [mfwm_pkg::FlagW-1:0] flags;
  logic                       any_sd;
  logic                       any_sdb;
  logic                       some_n;
  logic                       all_n;
  mfwm_pkg::out_item_t        res;

  assign out_pop    = pop && !empty;
  assign room       = (res_cnt_q != 2'd2) || out_pop;
  assign item_pop_o = !item_empty_i && room;
  assign res_push   = item_pop_o && item_i.primed;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      win_d[i] = win_q[i+3];
    end
    win_d[6] = item_i.up;
    win_d[7] = item_i.mid;
    win_d[8] = item_i.pix;
  end

  // Cells are column-major, column 0 oldest; cells outside the frame read as empty.
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      nbr[i] = win_d[i];
      if ((i / 3 == 0) && !item_i.left_ok) begin
        nbr[i] = '0;
      end
      if ((i / 3 == 2) && !item_i.right_ok) begin
        nbr[i] = '0;
      end
      if ((i % 3 == 0) && !item_i.up_ok) begin
        nbr[i] = '0;
      end
      if ((i % 3 == 2) && !item_i.down_ok) begin
        nbr[i] = '0;
      end
    end
  end

  always_comb begin
    here    = win_d[4];
    any_sd  = 1'b0;
    any_sdb = 1'b0;
    for (int i = 0; i < 9; i++) begin
      any_sd  = any_sd || ((nbr[i] & Sd) != '0);
      any_sdb = any_sdb || ((nbr[i] & (Sd | mfwm_pkg::FlBand)) != '0);
    end
    some_n = ((nbr[1] | nbr[7] | nbr[3] | nbr[5]) & Sd) != '0;
    all_n  = ((nbr[1] & Sd) != '0) && ((nbr[7] & Sd) != '0) &&
             ((nbr[3] & Sd) != '0) && ((nbr[5] & Sd) != '0);
    flags  = here;
    unique case (mfwm_pkg::mode_e'(mode_i))
      mfwm_pkg::ModeDilate: begin
        if (((here & Sd) == '0) && any_sd) begin
          flags = here | mfwm_pkg::FlDilated;
        end
      end
      mfwm_pkg::ModeBoundary: begin
        if (((here & Sd) != '0) && some_n && !all_n) begin
          flags = here | mfwm_pkg::FlBoundary;
        end
      end
      mfwm_pkg::ModeBand: begin
        if ((here & mfwm_pkg::FlSolid) != '0) begin
          flags = here;
        end else if (((here & mfwm_pkg::FlDilated) != '0) || any_sdb) begin
          flags = here | mfwm_pkg::FlBand;
        end
      end
      mfwm_pkg::ModeClose: begin
        if ((here & (Sd | mfwm_pkg::FlNoHole)) == '0) begin
          flags = here | mfwm_pkg::FlDilated;
        end
      end
      default: flags = here;
    endcase
    if (edge_band_i && !(item_i.left_ok && item_i.right_ok && item_i.up_ok &&
                         item_i.down_ok)) begin
      flags = flags | mfwm_pkg::FlBand;
    end
  end

  always_comb begin
    res              = '0;
    res.result_flags = flags;
    res.out_column   = item_i.col;
    res.out_row      = item_i.row;
    res.frame_end    = item_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (item_pop_o) begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_q[wr_ptr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= 1'b0;
      rd_ptr_q  <= 1'b0;
      res_cnt_q <= 2'd0;
    end else begin
      if (res_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (out_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (res_push && !out_pop) begin
        res_cnt_q <= res_cnt_q + 2'd1;
      end else if (!res_push && out_pop) begin
        res_cnt_q <= res_cnt_q - 2'd1;
      end
    end
  end

  assign empty      = (res_cnt_q == 2'd0);
  assign out_item_o = res_q[rd_ptr_q];

endmodule

@@ verif/tb_mask_flag_window_morphology_unit.sv @@
// Self-checking testbench for mask_flag_window_morphology_unit: a 3x3 flag window predictor
// with its own line stores checks every result transfer in order. Depends on mfwm_pkg and the RTL.
module tb_mask_flag_window_morphology_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomItems   = 560;
  localparam int unsigned HoldCycles    = 600;
  localparam int unsigned SettleCycles  = 16;
  localparam int unsigned WatchdogLimit = 5000;

  class flag_window_checker;
    mfwm_pkg::mode_e                      rule_mode;
    logic [mfwm_pkg::WidthW-1:0]          width_reg;
    logic [mfwm_pkg::HeightW-1:0]         height_reg;
    bit                                   edge_band_on;
    logic [mfwm_pkg::FlagW-1:0]           upper_line [mfwm_pkg::LineDepth];
    logic [mfwm_pkg::FlagW-1:0]           middle_line [mfwm_pkg::LineDepth];
    logic [mfwm_pkg::FlagW-1:0]           win [9];
    int unsigned                          in_col;
    int unsigned                          in_row;
    int unsigned                          emitted;
    mfwm_pkg::out_item_t                  centres_due [$];
    int unsigned                          errors;

    function new();
      rule_mode = mfwm_pkg::ModeDilate;
      width_reg = mfwm_pkg::MaxWidth;
      height_reg = mfwm_pkg::HeightW'(1);
      edge_band_on = 1'b0;
      foreach (upper_line[i]) begin
        upper_line[i] = '0;
        middle_line[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      in_col = 0;
      in_row = 0;
      emitted = 0;
      errors = 0;
    endfunction

    function void note_config(mfwm_pkg::cfg_idx_e idx, logic [mfwm_pkg::CfgDataW-1:0] data);
      case (idx)
        mfwm_pkg::CfgMode: rule_mode = mfwm_pkg::mode_e'(data[1:0]);
        mfwm_pkg::CfgWidth: width_reg = data[mfwm_pkg::WidthW-1:0];
        mfwm_pkg::CfgHeight: height_reg = data[mfwm_pkg::HeightW-1:0];
        default: edge_band_on = data[0];
      endcase
    endfunction

    function int unsigned eff_w();
      int unsigned w = width_reg;
      if (w == 0) w = 1;
      if (w > mfwm_pkg::LineDepth) w = mfwm_pkg::LineDepth;
      return w;
    endfunction

    function int unsigned eff_h();
      int unsigned h = height_reg;
      if (h == 0) h = 1;
      if (h > (1 << mfwm_pkg::RowW)) h = 1 << mfwm_pkg::RowW;
      return h;
    endfunction

    function bit frame_active();
      return in_col != 0 || in_row != 0 || emitted != 0;
    endfunction

    function int unsigned pending();
      return centres_due.size();
    endfunction

    function logic [mfwm_pkg::FlagW-1:0] neighbour(int dx, int dy, int unsigned col, row, w, h);
      if (dx < 0 && col == 0) return '0;
      if (dx > 0 && col + 1 >= w) return '0;
      if (dy < 0 && row == 0) return '0;
      if (dy > 0 && row + 1 >= h) return '0;
      return win[(dx + 1) * 3 + (dy + 1)];
    endfunction

    function bit any_set(logic [mfwm_pkg::FlagW-1:0] mask, int unsigned col, row, w, h);
      for (int dy = -1; dy <= 1; dy++) begin
        for (int dx = -1; dx <= 1; dx++) begin
          if ((neighbour(dx, dy, col, row, w, h) & mask) != 0) return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function logic [mfwm_pkg::FlagW-1:0] rule_flags(int unsigned col, row, w, h);
      logic [mfwm_pkg::FlagW-1:0] here;
      logic [mfwm_pkg::FlagW-1:0] sd;
      int n;
      here = win[4];
      sd = mfwm_pkg::FlSolid | mfwm_pkg::FlDilated;
      n = 0;
      case (rule_mode)
        mfwm_pkg::ModeDilate: begin
          if ((here & sd) == 0 && any_set(sd, col, row, w, h)) here |= mfwm_pkg::FlDilated;
        end
        mfwm_pkg::ModeBoundary: begin
          if ((here & sd) != 0) begin
            if ((neighbour(-1, 0, col, row, w, h) & sd) != 0) n++;
            if ((neighbour(1, 0, col, row, w, h) & sd) != 0) n++;
            if ((neighbour(0, -1, col, row, w, h) & sd) != 0) n++;
            if ((neighbour(0, 1, col, row, w, h) & sd) != 0) n++;
            if (n > 0 && n < 4) here |= mfwm_pkg::FlBoundary;
          end
        end
        mfwm_pkg::ModeBand: begin
          if ((here & mfwm_pkg::FlSolid) == 0) begin
            if ((here & mfwm_pkg::FlDilated) != 0 ||
                any_set(sd | mfwm_pkg::FlBand, col, row, w, h)) begin
              here |= mfwm_pkg::FlBand;
            end
          end
        end
        default: begin
          if ((here & (sd | mfwm_pkg::FlNoHole)) == 0) here |= mfwm_pkg::FlDilated;
        end
      endcase
      return here;
    endfunction

    function void note_input(mfwm_pkg::in_item_t it);
      int unsigned w, h, c, q, col, row;
      logic [mfwm_pkg::FlagW-1:0] pix, up, mid, flags;
      bit primed;
      mfwm_pkg::out_item_t res;
      w = eff_w();
      h = eff_h();
      if (it.kind && !frame_active()) return;
      pix = it.kind ? '0 : it.pixel_flags;
      primed = (in_row >= 2) || (in_row == 1 && in_col >= 1);
      c = in_col;
      up = '0;
      mid = '0;
      if (c < mfwm_pkg::LineDepth) begin
        up = upper_line[c];
        mid = middle_line[c];
        upper_line[c] = mid;
        middle_line[c] = pix;
      end
      for (int i = 0; i < 6; i++) win[i] = win[i + 3];
      win[6] = up;
      win[7] = mid;
      win[8] = pix;
      if (in_col + 1 >= w) begin
        in_col = 0;
        if (in_row < mfwm_pkg::RowMax) in_row++;
      end else begin
        in_col++;
      end
      if (!primed) return;
      q = emitted;
      col = q % w;
      row = q / w;
      flags = rule_flags(col, row, w, h);
      if (edge_band_on && (col == 0 || col + 1 >= w || row == 0 || row + 1 >= h)) begin
        flags |= mfwm_pkg::FlBand;
      end
      res.result_flags = flags;
      res.out_column = mfwm_pkg::ColW'(col);
      res.out_row = mfwm_pkg::RowW'(row);
      res.frame_end = (q + 1 >= w * h);
      if (res.frame_end) begin
        in_col = 0;
        in_row = 0;
        emitted = 0;
      end else begin
        emitted = q + 1;
      end
      centres_due.insert(centres_due.size(), res);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(mfwm_pkg::out_item_t got);
      mfwm_pkg::out_item_t want;
      if (centres_due.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, got);
        errors++;
        return;
      end
      want = centres_due.pop_front();
      compare_field("result_flags", 16'(want.result_flags), 16'(got.result_flags));
      compare_field("out_column", 16'(want.out_column), 16'(got.out_column));
      compare_field("out_row", 16'(want.out_row), 16'(got.out_row));
      compare_field("frame_end", 16'(want.frame_end), 16'(got.frame_end));
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          push;
  logic                          full;
  mfwm_pkg::in_item_t            in_item;
  logic                          empty;
  logic                          pop;
  mfwm_pkg::out_item_t           out_item;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [mfwm_pkg::CfgIdxW-1:0]  cfg_index;
  logic [mfwm_pkg::CfgDataW-1:0] cfg_data;

  flag_window_checker chk = new();
  int unsigned burst_left = 0;
  int unsigned items_sent = 0;
  int unsigned stall_cycles = 0;
  bit hold_rx_req = 1'b0;

  mask_flag_window_morphology_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WatchdogLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [mfwm_pkg::FlagW-1:0] random_flags(int unsigned density);
    logic [mfwm_pkg::FlagW-1:0] flags;
    flags = mfwm_pkg::FlagW'($urandom_range(0, 63));
    if (density == 1 && $urandom_range(0, 3) != 0) begin
      flags &= ~(mfwm_pkg::FlSolid | mfwm_pkg::FlDilated | mfwm_pkg::FlBand);
    end
    if (density == 2 && $urandom_range(0, 3) != 0) flags |= mfwm_pkg::FlSolid;
    return flags;
  endfunction

  task automatic send_item(mfwm_pkg::in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(0, 15) == 0) gap = $urandom_range(10, 30);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    push <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (full);
    chk.note_input(it);
    items_sent++;
  endtask

  task automatic send_pixel(logic [mfwm_pkg::FlagW-1:0] flags);
    mfwm_pkg::in_item_t it;
    it.kind = 1'b0;
    it.pixel_flags = flags;
    send_item(it);
  endtask

  task automatic send_flush();
    mfwm_pkg::in_item_t it;
    it.kind = 1'b1;
    it.pixel_flags = random_flags(0);
    send_item(it);
  endtask

  task automatic finish_frame();
    while (chk.frame_active()) send_flush();
  endtask

  task automatic settle();
    push <= 1'b0;
    while (chk.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(mfwm_pkg::cfg_idx_e idx, int unsigned value);
    logic [mfwm_pkg::CfgDataW-1:0] data;
    data = mfwm_pkg::CfgDataW'(value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready);
    chk.note_config(idx, data);
  endtask

  task automatic configure(mfwm_pkg::mode_e m, int unsigned w, int unsigned h, bit eb);
    write_reg(mfwm_pkg::CfgMode, m);
    write_reg(mfwm_pkg::CfgWidth, w);
    write_reg(mfwm_pkg::CfgHeight, h);
    write_reg(mfwm_pkg::CfgEdgeBand, eb);
    cfg_valid <= 1'b0;
  endtask

  task automatic stream_frame(int unsigned body, int unsigned count, int unsigned density);
    mfwm_pkg::in_item_t it;
    for (int unsigned k = 0; k < count; k++) begin
      it.pixel_flags = random_flags(density);
      if (k < body) it.kind = chk.frame_active() && $urandom_range(0, 11) == 0;
      else it.kind = $urandom_range(0, 11) != 0;
      send_item(it);
    end
  endtask

  initial begin : result_sink
    int unsigned tick;
    logic [15:0] rx_bits;
    tick = 0;
    rx_bits = '1;
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) chk.check_result(out_item);
      tick++;
      if (tick % 32 == 0) begin
        case ($urandom_range(0, 3))
          0: rx_bits = '1;
          1: rx_bits = 16'($urandom);
          2: rx_bits = 16'($urandom | $urandom);
          default: rx_bits = 16'hffff ^ (16'h1 << $urandom_range(0, 15));
        endcase
      end
      if (hold_rx_req) begin
        hold_rx_req = 1'b0;
        pop <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        pop <= rx_bits[tick % 16];
      end
    end
  end

  initial begin : stimulus
    int unsigned phase_no, w, h, body, count, density, stop_at;
    bit truncate;
    rst_ni <= 1'b0;
    push <= 1'b0;
    in_item <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single-pixel frame: idle flush, a pixel, a flush, then a pixel during the drain.
    configure(mfwm_pkg::ModeDilate, 0, 0, 1'b1);
    send_flush();
    send_pixel(6'h3f);
    send_flush();
    send_pixel(6'h00);
    settle();

    // Flush before frame end, and a pixel among the drain items.
    configure(mfwm_pkg::ModeBoundary, 3, 2, 1'b0);
    send_pixel(6'h01);
    send_pixel(6'h01);
    send_pixel(6'h00);
    send_flush();
    send_pixel(6'h02);
    send_pixel(6'h3f);
    send_flush();
    send_pixel(6'h15);
    send_flush();
    send_flush();
    finish_frame();
    settle();

    configure(mfwm_pkg::ModeBand, 2, 2, 1'b1);
    send_pixel(6'h08);
    send_pixel(6'h00);
    send_pixel(6'h00);
    send_pixel(6'h20);
    finish_frame();
    settle();

    // The frame shrinks under way, so the second result after the height write closes it.
    configure(mfwm_pkg::ModeClose, 2, 2, 1'b0);
    send_pixel(6'h00);
    send_pixel(6'h10);
    send_pixel(6'h3f);
    settle();
    write_reg(mfwm_pkg::CfgHeight, 1);
    cfg_valid <= 1'b0;
    send_pixel(6'h00);
    finish_frame();

    phase_no = 0;
    count = items_sent + RandomItems;
    while (items_sent < count) begin
      settle();
      case ($urandom_range(0, 9))
        0: w = 1;
        1: w = 0;
        2: w = $urandom_range(13, 40);
        default: w = $urandom_range(2, 12);
      endcase
      case ($urandom_range(0, 5))
        0: h = 0;
        1: h = 1;
        default: h = $urandom_range(2, 6);
      endcase
      truncate = $urandom_range(0, 9) == 0;
      if (phase_no == 3) begin
        w = 12;
        h = 8;
        truncate = 1'b0;
      end
      configure(mfwm_pkg::mode_e'($urandom_range(0, 3)), w, h, 1'($urandom_range(0, 1)));
      if (phase_no == 3) hold_rx_req = 1'b1;
      density = $urandom_range(0, 2);
      body = chk.eff_w() * chk.eff_h();
      stop_at = body + chk.eff_w() + 1;
      if (truncate) stop_at = $urandom_range(1, stop_at);
      stream_frame(body, stop_at, density);
      if (!truncate) begin
        finish_frame();
        if ($urandom_range(0, 3) == 0) send_flush();
      end
      phase_no++;
    end

    // Start of the widest frame, with the width register above the line store size.
    settle();
    configure(mfwm_pkg::mode_e'($urandom_range(0, 3)), 2047, 1, 1'b1);
    stream_frame(mfwm_pkg::LineDepth, mfwm_pkg::LineDepth + 8, $urandom_range(0, 2));

    settle();
    repeat (SettleCycles) @(posedge clk_i);
    if (chk.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ mask_flag_window_morphology_unit.f @@
hw/rtl/mfwm_pkg.sv
hw/rtl/mfwm_geom.sv
hw/rtl/mfwm_queue.sv
hw/rtl/mfwm_front.sv
hw/rtl/mfwm_back.sv
hw/rtl/mask_flag_window_morphology_unit.sv
verif/tb_mask_flag_window_morphology_unit.sv
